FILE: rtl/core/bbe_pkg.sv
// Shared types, character constants and small arithmetic helpers for the Bubble Babble encoder.
package bbe_pkg;

	typedef logic [6:0] char_t;
	typedef logic [2:0] count_t;

	localparam int unsigned MaxChars  = 5;
	localparam char_t       CHAR_X    = 7'h78;
	localparam char_t       CHAR_DASH = 7'h2d;
	localparam logic [5:0]  SEED_INIT = 6'd1;
	localparam logic [5:0]  SEED_MOD  = 6'd36;

	function automatic char_t consonant(input logic [3:0] idx);
		char_t c;
		case (idx)
			4'd0:    c = 7'h62; // b
			4'd1:    c = 7'h63; // c
			4'd2:    c = 7'h64; // d
			4'd3:    c = 7'h66; // f
			4'd4:    c = 7'h67; // g
			4'd5:    c = 7'h68; // h
			4'd6:    c = 7'h6b; // k
			4'd7:    c = 7'h6c; // l
			4'd8:    c = 7'h6d; // m
			4'd9:    c = 7'h6e; // n
			4'd10:   c = 7'h70; // p
			4'd11:   c = 7'h72; // r
			4'd12:   c = 7'h73; // s
			4'd13:   c = 7'h74; // t
			4'd14:   c = 7'h76; // v
			default: c = 7'h7a; // z
		endcase
		return c;
	endfunction

	function automatic char_t vowel(input logic [2:0] idx);
		char_t c;
		case (idx)
			3'd0:    c = 7'h61; // a
			3'd1:    c = 7'h65; // e
			3'd2:    c = 7'h69; // i
			3'd3:    c = 7'h6f; // o
			3'd4:    c = 7'h75; // u
			default: c = 7'h79; // y
		endcase
		return c;
	endfunction

	// quotient by six for a seed below 36
	function automatic logic [2:0] div6(input logic [5:0] s);
		logic [10:0] p;
		p = {5'd0, s} * 11'd43;
		return p[10:8];
	endfunction

	function automatic logic [2:0] mod6(input logic [5:0] s);
		logic [5:0] r;
		r = s - ({3'd0, div6(s)} * 6'd6);
		return r[2:0];
	endfunction

	// (digit + seed digit) folded back into 0..5
	function automatic logic [2:0] vowel_idx(input logic [1:0] d, input logic [2:0] s);
		logic [3:0] t;
		t = {2'd0, d} + {1'b0, s};
		if (t >= 4'd6) begin
			t = t - 4'd6;
		end
		return t[2:0];
	endfunction

	// remainder by 36 for values below 2216: reciprocal estimate, one correction
	function automatic logic [5:0] mod36(input logic [11:0] x);
		logic [21:0] p;
		logic [5:0]  q;
		logic [11:0] r;
		p = {10'd0, x} * 22'd1820;
		q = p[21:16];
		r = x - ({6'd0, q} * 12'd36);
		if (r >= {6'd0, SEED_MOD}) begin
			r = r - {6'd0, SEED_MOD};
		end
		return r[5:0];
	endfunction

endpackage

FILE: rtl/core/bbe_in_if.sv
// Input channel: one data byte or an end marker per transaction.
interface bbe_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       is_end;

	modport source (output valid, output data_byte, output is_end, input ready);
	modport sink (input valid, input data_byte, input is_end, output ready);
endinterface

FILE: rtl/core/bbe_out_if.sv
// Output channel: one encoded ASCII character per transaction.
interface bbe_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] out_char;
	logic       last_char;

	modport source (output valid, output out_char, output last_char, input ready);
	modport sink (input valid, input out_char, input last_char, output ready);
endinterface

FILE: rtl/core/bubble_babble_encoder_top.sv
// Bubble Babble encoder top level: input register, expansion into a character buffer, serial output.
//
//  channel    dir   payload                     meaning
//  data_in    in    data_byte[7:0], is_end      one byte, or close the encoding
//  text_out   out   out_char[6:0], last_char    one character, last on the final 'x'
//
//  A byte yields three or four characters, an end marker one, four or five; the output sends one
//  character a cycle while text_out.ready is high, and the next byte enters the character buffer
//  as its last character leaves. Each transaction passes the input register, then the buffer.
//  An input transaction is taken while the input register is empty or moves its byte into the buffer.
//  Reset sets the seed to 1 and clears pair phase, started flag and buffer count.
module bubble_babble_encoder_top (
	input  logic           clk,
	input  logic           arst_n,
	bbe_in_if.sink         data_in,
	bbe_out_if.source      text_out
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             end_s1;

	logic [5:0]       seed_q;
	logic             phase_q;
	logic             started_q;
	logic [7:0]       held_q;

	bbe_pkg::char_t   buf_q [bbe_pkg::MaxChars];
	bbe_pkg::count_t  cnt_q;
	logic             last_q;

	logic             pop;
	logic             buf_free;
	logic             load;

	logic [2:0]       s_lo;
	logic [2:0]       s_hi;
	logic             open;
	bbe_pkg::char_t   core [4];
	bbe_pkg::count_t  core_n;
	bbe_pkg::char_t   slots [bbe_pkg::MaxChars];
	bbe_pkg::count_t  slots_n;
	logic [5:0]       seed_next;

	assign pop      = text_out.valid && text_out.ready;
	assign buf_free = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && text_out.ready);
	assign load     = valid_s1 && buf_free;

	assign data_in.ready = !valid_s1 || load;

	assign text_out.valid     = (cnt_q != 3'd0);
	assign text_out.out_char  = buf_q[0];
	assign text_out.last_char = last_q && (cnt_q == 3'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (data_in.ready) begin
			valid_s1 <= data_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (data_in.valid && data_in.ready) begin
			byte_s1 <= data_in.data_byte;
			end_s1  <= data_in.is_end;
		end
	end

	always_comb begin
		s_lo      = bbe_pkg::mod6(seed_q);
		s_hi      = bbe_pkg::div6(seed_q);
		open      = !phase_q && !started_q;
		seed_next = bbe_pkg::mod36(({6'd0, seed_q} * 12'd5) + ({4'd0, held_q} * 12'd7)
			+ {4'd0, byte_s1});
		core[0] = bbe_pkg::CHAR_X;
		core[1] = bbe_pkg::CHAR_X;
		core[2] = bbe_pkg::CHAR_X;
		core[3] = bbe_pkg::CHAR_X;
		core_n  = 3'd3;
		if (end_s1) begin
			if (!phase_q) begin
				core[0] = bbe_pkg::vowel(s_lo);
				core[2] = bbe_pkg::vowel(s_hi);
				core_n  = 3'd4;
			end else begin
				core_n  = 3'd1;
			end
		end else if (!phase_q) begin
			core[0] = bbe_pkg::vowel(bbe_pkg::vowel_idx(byte_s1[7:6], s_lo));
			core[1] = bbe_pkg::consonant(byte_s1[5:2]);
			core[2] = bbe_pkg::vowel(bbe_pkg::vowel_idx(byte_s1[1:0], s_hi));
		end else begin
			core[0] = bbe_pkg::consonant(byte_s1[7:4]);
			core[1] = bbe_pkg::CHAR_DASH;
			core[2] = bbe_pkg::consonant(byte_s1[3:0]);
		end
		if (open) begin
			slots[0] = bbe_pkg::CHAR_X;
			slots[1] = core[0];
			slots[2] = core[1];
			slots[3] = core[2];
			slots[4] = core[3];
			slots_n  = core_n + 3'd1;
		end else begin
			slots[0] = core[0];
			slots[1] = core[1];
			slots[2] = core[2];
			slots[3] = core[3];
			slots[4] = core[3];
			slots_n  = core_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q    <= bbe_pkg::SEED_INIT;
			phase_q   <= 1'b0;
			started_q <= 1'b0;
		end else if (load) begin
			if (end_s1) begin
				seed_q    <= bbe_pkg::SEED_INIT;
				phase_q   <= 1'b0;
				started_q <= 1'b0;
			end else if (!phase_q) begin
				phase_q   <= 1'b1;
				started_q <= 1'b1;
			end else begin
				seed_q    <= seed_next;
				phase_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !end_s1 && !phase_q) begin
			held_q <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (load) begin
			cnt_q <= slots_n;
		end else if (pop) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			last_q <= end_s1;
			for (int i = 0; i < bbe_pkg::MaxChars; i++) begin
				buf_q[i] <= slots[i];
			end
		end else if (pop) begin
			for (int i = 0; i < bbe_pkg::MaxChars - 1; i++) begin
				buf_q[i] <= buf_q[i + 1];
			end
		end
	end

	a_cnt_bound : assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd5)
		else $error("character count beyond buffer depth");

	a_seed_range : assert property (@(posedge clk) disable iff (!arst_n)
		seed_q < bbe_pkg::SEED_MOD)
		else $error("seed out of range");

	a_phase_started : assert property (@(posedge clk) disable iff (!arst_n)
		!(phase_q && !started_q))
		else $error("odd byte held without opening character");

	a_end_resets : assert property (@(posedge clk) disable iff (!arst_n)
		load && end_s1 |=> seed_q == bbe_pkg::SEED_INIT && !phase_q && !started_q)
		else $error("state not returned to initial values after end marker");

endmodule
